/* sv/pip_pkg.sv */
// shared types and constants for the point-in-polygon crossing test
`default_nettype none
package pip_pkg;

  // per-item control carried from the front end to the edge unit
  typedef struct packed {
    logic start;
    logic last;
  } pip_ctl_t;

  localparam int unsigned CTL_BITS      = 2;
  localparam int unsigned FIFO_DEPTH    = 4;
  localparam int unsigned FIFO_PTR_BITS = 2;

endpackage
`default_nettype wire

/* sv/pip_front.sv */
// front end: accepts vertices, tracks first and previous vertex and the held query point
`default_nettype none
module pip_front
  import pip_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [COORD_BITS-1:0]   vx,
  input  wire logic [COORD_BITS-1:0]   vy,
  input  wire logic [COORD_BITS-1:0]   qx,
  input  wire logic [COORD_BITS-1:0]   qy,
  input  wire logic                    last,
  input  wire logic                    q_ready,
  output logic                         q_valid,
  output pip_ctl_t                     q_ctl,
  output logic [8*COORD_BITS-1:0]      q_data   // prev, vertex, first, query; x then y
);

  logic [COORD_BITS-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic [COORD_BITS-1:0] held_qx_r, held_qy_r;
  logic                  in_poly_r;
  logic                  accept;
  logic                  start;
  logic [COORD_BITS-1:0] fx, fy, hqx, hqy;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign start    = !in_poly_r;

  assign fx  = start ? vx : first_x_r;
  assign fy  = start ? vy : first_y_r;
  assign hqx = start ? qx : held_qx_r;
  assign hqy = start ? qy : held_qy_r;

  assign q_valid     = in_valid;
  assign q_ctl.start = start;
  assign q_ctl.last  = last;
  assign q_data      = {hqy, hqx, fy, fx, vy, vx, prev_y_r, prev_x_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_poly_r <= 1'b0;
      first_x_r <= '0;
      first_y_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
      held_qx_r <= '0;
      held_qy_r <= '0;
    end else if (accept) begin
      first_x_r <= fx;
      first_y_r <= fy;
      held_qx_r <= hqx;
      held_qy_r <= hqy;
      prev_x_r  <= vx;
      prev_y_r  <= vy;
      in_poly_r <= !last;
    end
  end

endmodule
`default_nettype wire

/* sv/pip_fifo.sv */
// short queue between the front end and the edge unit
`default_nettype none
module pip_fifo
  import pip_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam logic [FIFO_PTR_BITS:0] FIFO_FULL_CNT = (FIFO_PTR_BITS+1)'(FIFO_DEPTH);

  logic [WIDTH-1:0]         mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_PTR_BITS:0]   cnt_r;
  logic                     push, pop;

  assign push_ready = (cnt_r != FIFO_FULL_CNT);
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (FIFO_PTR_BITS+1)'(push) - (FIFO_PTR_BITS+1)'(pop);
    end
  end

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue empty but pointers differ");

  a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == FIFO_FULL_CNT) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue full but pointers differ");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_FULL_CNT)
    else $error("queue count above depth");

endmodule
`default_nettype wire

/* sv/pip_back.sv */
// edge unit: cross-multiplied edge tests, crossing count and result register
`default_nettype none
module pip_back
  import pip_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned COUNT_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  output logic                       q_ready,
  input  wire pip_ctl_t              q_ctl,
  input  wire logic [8*COORD_BITS-1:0] q_data,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output logic                       res_inside,
  output logic [COUNT_BITS-1:0]      res_count
);

  localparam int unsigned W = COORD_BITS;
  localparam int unsigned D = COORD_BITS + 1;
  localparam int unsigned P = 2 * D;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  function automatic logic signed [D-1:0] diff(input logic [W-1:0] a, input logic [W-1:0] b);
    logic signed [D-1:0] ea, eb;
    ea = $signed({a[W-1], a});
    eb = $signed({b[W-1], b});
    return ea - eb;
  endfunction

  function automatic logic straddle(input logic [W-1:0] y1, input logic [W-1:0] y2,
                                    input logic [W-1:0] q);
    logic signed [W-1:0] s1, s2, sq;
    s1 = $signed(y1);
    s2 = $signed(y2);
    sq = $signed(q);
    return (s1 > sq && s2 < sq) || (s1 < sq && s2 > sq);
  endfunction

  logic [W-1:0] px, py, vx, vy, fx, fy, qx, qy;
  assign {qy, qx, fy, fx, vy, vx, py, px} = q_data;

  // stage 1: differences
  logic                s1_valid_r;
  pip_ctl_t            s1_ctl_r;
  logic signed [D-1:0] a_aa_r, a_ab_r, a_ac_r, a_ad_r, b_aa_r, b_ab_r, b_ac_r, b_ad_r;
  logic                a_str_r, b_str_r, a_neg_r, b_neg_r;

  // stage 2: products
  logic                s2_valid_r;
  pip_ctl_t            s2_ctl_r;
  logic signed [P-1:0] a_p1_r, a_p2_r, b_p1_r, b_p2_r;
  logic                a_str2_r, b_str2_r, a_neg2_r, b_neg2_r;

  // accumulation and result
  logic [COUNT_BITS-1:0] count_r;
  logic                  parity_r;
  logic                  out_valid_r;
  logic                  out_inside_r;
  logic [COUNT_BITS-1:0] out_count_r;

  logic                  stall, adv;
  logic                  hit_a, hit_b;
  logic [COUNT_BITS-1:0] base_cnt, count_nxt;
  logic [COUNT_BITS:0]   sum;
  logic                  base_par, parity_nxt;

  assign stall   = s2_valid_r && s2_ctl_r.last && out_valid_r && !res_ready;
  assign adv     = !stall;
  assign q_ready = adv;

  // x of the edge at the query's y lies right of the query, multiplied through by dy
  assign hit_a = a_str2_r && (a_neg2_r ? (a_p1_r > a_p2_r) : (a_p1_r < a_p2_r));
  assign hit_b = b_str2_r && (b_neg2_r ? (b_p1_r > b_p2_r) : (b_p1_r < b_p2_r));

  assign base_cnt   = s2_ctl_r.start ? '0 : count_r;
  assign base_par   = s2_ctl_r.start ? 1'b0 : parity_r;
  assign sum        = {1'b0, base_cnt} + (COUNT_BITS+1)'(hit_a) + (COUNT_BITS+1)'(hit_b);
  assign count_nxt  = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
  assign parity_nxt = base_par ^ hit_a ^ hit_b;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl_r <= q_ctl;
      // edge from previous vertex to this one, absent on a polygon's first vertex
      a_aa_r  <= diff(qx, px);
      a_ab_r  <= diff(vy, py);
      a_ac_r  <= diff(vx, px);
      a_ad_r  <= diff(qy, py);
      a_str_r <= !q_ctl.start && straddle(py, vy, qy);
      a_neg_r <= $signed(vy) < $signed(py);
      // closing edge from this vertex back to the first
      b_aa_r  <= diff(qx, vx);
      b_ab_r  <= diff(fy, vy);
      b_ac_r  <= diff(fx, vx);
      b_ad_r  <= diff(qy, vy);
      b_str_r <= q_ctl.last && straddle(vy, fy, qy);
      b_neg_r <= $signed(fy) < $signed(vy);

      s2_ctl_r <= s1_ctl_r;
      a_p1_r   <= a_aa_r * a_ab_r;
      a_p2_r   <= a_ac_r * a_ad_r;
      b_p1_r   <= b_aa_r * b_ab_r;
      b_p2_r   <= b_ac_r * b_ad_r;
      a_str2_r <= a_str_r;
      b_str2_r <= b_str_r;
      a_neg2_r <= a_neg_r;
      b_neg2_r <= b_neg_r;
    end
    if (adv && s2_valid_r && s2_ctl_r.last) begin
      out_inside_r <= parity_nxt;
      out_count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      count_r     <= '0;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_r <= q_valid;
        s2_valid_r <= s1_valid_r;
        if (s2_valid_r) begin
          count_r  <= count_nxt;
          parity_r <= parity_nxt;
        end
      end
      if (adv && s2_valid_r && s2_ctl_r.last) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign res_valid  = out_valid_r;
  assign res_inside = out_inside_r;
  assign res_count  = out_count_r;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> s2_valid_r && $stable(s2_ctl_r))
    else $error("edge stage moved while result slot blocked");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_valid_r && s2_ctl_r.last) |=> out_valid_r)
    else $error("closing item gave no result");

  a_parity_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_count_r != COUNT_MAX) |-> (out_inside_r == out_count_r[0]))
    else $error("inside flag disagrees with unsaturated count");

endmodule
`default_nettype wire

/* sv/point_in_polygon_crossing_test.sv */
// top level of the even-odd point-in-polygon crossing test
`default_nettype none
// Streams one polygon vertex per item; the first item of a polygon also carries the
// query point, and the item with in_tlast set closes the polygon and yields one result
// (inside flag and crossing count, saturating at 2^COUNT_BITS-1). The block takes one
// item per clock while the queue is not full: a front end tracks the first and previous
// vertex, a four-entry queue decouples it from a three-register edge unit that tests the
// regular and the closing edge of each item with two signed multiplies apiece. A closing
// item passes through the queue, stage 1 and stage 2 before its result reaches the output
// register. A result not taken stalls the edge unit only once a further closing item
// reaches stage 2; the queue then keeps taking items until it fills.
module point_in_polygon_crossing_test
  import pip_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned COUNT_BITS = 10
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // vertex_x, vertex_y, query_x, query_y
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  input  wire logic                                  in_tlast,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // inside_res, crossings
  output logic [((1+COUNT_BITS+7)/8)*8-1:0]          out_tdata
);

  localparam int unsigned OUT_W = ((1 + COUNT_BITS + 7) / 8) * 8;
  localparam int unsigned QW    = 8 * COORD_BITS + CTL_BITS;

  logic                      f_valid, f_ready, b_valid, b_ready;
  pip_ctl_t                  f_ctl, b_ctl;
  logic [8*COORD_BITS-1:0]   f_data, b_data;
  logic                      res_inside;
  logic [COUNT_BITS-1:0]     res_count;

  pip_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .vx       (in_tdata[COORD_BITS-1:0]),
    .vy       (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .qx       (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .qy       (in_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .last     (in_tlast),
    .q_ready  (f_ready),
    .q_valid  (f_valid),
    .q_ctl    (f_ctl),
    .q_data   (f_data)
  );

  pip_fifo #(.WIDTH(QW)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_ctl, f_data}),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   ({b_ctl, b_data})
  );

  pip_back #(.COORD_BITS(COORD_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (b_valid),
    .q_ready    (b_ready),
    .q_ctl      (b_ctl),
    .q_data     (b_data),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_inside (res_inside),
    .res_count  (res_count)
  );

  assign out_tdata = OUT_W'({res_count, res_inside});

endmodule
`default_nettype wire
